@@ hw/rtl/mlp_pkg.sv @@
// shared types and constants for the manifest line parser
`default_nettype none

package mlp_pkg;

  // default path buffer size, in bytes
  localparam int unsigned PATH_BYTES_DEF = 256;

  // accepted digest lengths in hex characters, and the cap of the digest count
  localparam logic [6:0] DIGEST_LEN_SHORT = 7'd8;
  localparam logic [6:0] DIGEST_LEN_MID   = 7'd32;
  localparam logic [6:0] DIGEST_LEN_LONG  = 7'd64;
  localparam logic [6:0] DIGEST_LEN_MAX   = 7'd127;

  // cap of the path length field
  localparam int unsigned PATH_LEN_FIELD_MAX = 511;

  // character codes
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_UC_A  = 8'h41;
  localparam logic [7:0] CHR_UC_F  = 8'h46;
  localparam logic [7:0] CHR_LC_A  = 8'h61;
  localparam logic [7:0] CHR_LC_F  = 8'h66;

  // field of the line being parsed
  typedef enum logic [2:0] {
    PH_DIGEST = 3'd0,
    PH_GAP1   = 3'd1,
    PH_SIZE   = 3'd2,
    PH_GAP2   = 3'd3,
    PH_PATH   = 3'd4
  } phase_e;

  // kind of byte reported with each result
  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_DIGEST  = 3'd1,
    KIND_SIZE    = 3'd2,
    KIND_PATH    = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  // character class of one byte
  typedef struct packed {
    logic       is_nul;
    logic       is_eol;
    logic       is_blank;
    logic       is_hex;
    logic       is_digit;
    logic [3:0] nibble;
  } byte_class_t;

  // one result beat
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  nibble;
    logic [63:0] size;
    logic [6:0]  digest_len;
    logic [8:0]  plen;
    logic        status;
    logic        done;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mlp_classify.sv @@
// character classifier: zero byte, blank, end of line, hex digit and decimal digit
`default_nettype none

module mlp_classify (
  input  logic [7:0]          text_byte_i,
  output mlp_pkg::byte_class_t class_o
);

  logic is_num, is_lc, is_uc;

  // range checks
  assign is_num = (text_byte_i >= mlp_pkg::CHR_0)    && (text_byte_i <= mlp_pkg::CHR_9);
  assign is_lc  = (text_byte_i >= mlp_pkg::CHR_LC_A) && (text_byte_i <= mlp_pkg::CHR_LC_F);
  assign is_uc  = (text_byte_i >= mlp_pkg::CHR_UC_A) && (text_byte_i <= mlp_pkg::CHR_UC_F);

  // class flags and hex value
  always_comb begin
    class_o.is_nul   = (text_byte_i == mlp_pkg::CHR_NUL);
    class_o.is_eol   = (text_byte_i == mlp_pkg::CHR_CR) || (text_byte_i == mlp_pkg::CHR_LF);
    class_o.is_blank = (text_byte_i == mlp_pkg::CHR_SPACE) ||
                       (text_byte_i == mlp_pkg::CHR_TAB);
    class_o.is_digit = is_num;
    class_o.is_hex   = is_num || is_lc || is_uc;
    // low nibble of a letter a-f or A-F is 1..6, so add nine
    if (is_num) begin
      class_o.nibble = text_byte_i[3:0];
    end else if (is_lc || is_uc) begin
      class_o.nibble = text_byte_i[3:0] + 4'd9;
    end else begin
      class_o.nibble = 4'd0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mlp_core.sv @@
// line state and per-byte result logic of the manifest line parser
`default_nettype none

module mlp_core #(
  parameter int unsigned PATH_BYTES = mlp_pkg::PATH_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [7:0]           text_byte_i,
  output mlp_pkg::result_t     result_o
);

  localparam int unsigned PW = $clog2(PATH_BYTES + 1);

  mlp_pkg::byte_class_t cls;

  mlp_pkg::phase_e phase_q, phase_d;
  logic [6:0]      dcount_q, dcount_d;
  logic            dbad_q, dbad_d;
  logic [63:0]     size_q, size_d;
  logic            snz_q, snz_d;
  logic            sbad_q, sbad_d;
  logic [PW-1:0]   pcount_q, pcount_d;
  logic            ended_q, ended_d;

  logic [63:0]     size_next;
  logic [PW-1:0]   pcount_inc;
  logic [PW-1:0]   plen_sel;
  logic            bad;

  mlp_classify u_classify (
    .text_byte_i (text_byte_i),
    .class_o     (cls)
  );

  // size times ten plus the new digit
  assign size_next = {size_q[60:0], 3'b000} + {size_q[62:0], 1'b0} +
                     {60'd0, cls.nibble};

  // path count saturates at the buffer size
  assign pcount_inc = (pcount_q < PW'(PATH_BYTES)) ? pcount_q + PW'(1) : pcount_q;

  // verdict at end of line
  assign bad = dbad_q ||
               ((dcount_q != mlp_pkg::DIGEST_LEN_SHORT) &&
                (dcount_q != mlp_pkg::DIGEST_LEN_MID) &&
                (dcount_q != mlp_pkg::DIGEST_LEN_LONG)) ||
               !snz_q || sbad_q ||
               (pcount_q == '0) || (pcount_q >= PW'(PATH_BYTES));

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    dcount_d = dcount_q;
    dbad_d   = dbad_q;
    size_d   = size_q;
    snz_d    = snz_q;
    sbad_d   = sbad_q;
    pcount_d = pcount_q;
    ended_d  = ended_q;

    result_o.kind   = mlp_pkg::KIND_IGNORED;
    result_o.nibble = 4'd0;
    result_o.size   = 64'd0;
    result_o.status = 1'b0;
    result_o.done   = 1'b0;

    if (cls.is_nul) begin
      result_o.kind   = mlp_pkg::KIND_END;
      result_o.done   = 1'b1;
      result_o.status = bad;
      result_o.size   = bad ? 64'd0 : size_q;
      // back to the start of a fresh line
      phase_d  = mlp_pkg::PH_DIGEST;
      dcount_d = 7'd0;
      dbad_d   = 1'b0;
      size_d   = 64'd0;
      snz_d    = 1'b0;
      sbad_d   = 1'b0;
      pcount_d = '0;
      ended_d  = 1'b0;
    end else if (!ended_q) begin
      if (cls.is_eol) begin
        ended_d = 1'b1;
        if (phase_q == mlp_pkg::PH_DIGEST) begin
          dbad_d = 1'b1;
        end
      end else begin
        case (phase_q)
          mlp_pkg::PH_DIGEST: begin
            if (cls.is_blank) begin
              phase_d = mlp_pkg::PH_GAP1;
            end else begin
              result_o.kind = mlp_pkg::KIND_DIGEST;
              if (dcount_q != mlp_pkg::DIGEST_LEN_MAX) begin
                dcount_d = dcount_q + 7'd1;
              end
              if (cls.is_hex) begin
                result_o.nibble = cls.nibble;
              end else begin
                dbad_d = 1'b1;
              end
            end
          end
          mlp_pkg::PH_GAP1, mlp_pkg::PH_SIZE: begin
            if (cls.is_blank) begin
              if (phase_q == mlp_pkg::PH_SIZE) begin
                phase_d = mlp_pkg::PH_GAP2;
              end
            end else begin
              phase_d       = mlp_pkg::PH_SIZE;
              result_o.kind = mlp_pkg::KIND_SIZE;
              snz_d         = 1'b1;
              if (cls.is_digit) begin
                size_d = size_next;
              end else begin
                sbad_d = 1'b1;
              end
            end
          end
          mlp_pkg::PH_GAP2: begin
            if (!cls.is_blank) begin
              phase_d       = mlp_pkg::PH_PATH;
              result_o.kind = mlp_pkg::KIND_PATH;
              pcount_d      = pcount_inc;
            end
          end
          default: begin
            result_o.kind = mlp_pkg::KIND_PATH;
            pcount_d      = pcount_inc;
          end
        endcase
      end
    end

    // lengths as they stand after this byte, or before the reset on a zero byte
    result_o.digest_len = cls.is_nul ? dcount_q : dcount_d;
    plen_sel            = cls.is_nul ? pcount_q : pcount_d;
    result_o.plen       = (plen_sel > PW'(mlp_pkg::PATH_LEN_FIELD_MAX)) ?
                          9'(mlp_pkg::PATH_LEN_FIELD_MAX) : 9'(plen_sel);
  end

  // line state, updated as each byte moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mlp_pkg::PH_DIGEST;
      dcount_q <= 7'd0;
      dbad_q   <= 1'b0;
      size_q   <= 64'd0;
      snz_q    <= 1'b0;
      sbad_q   <= 1'b0;
      pcount_q <= '0;
      ended_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      dcount_q <= dcount_d;
      dbad_q   <= dbad_d;
      size_q   <= size_d;
      snz_q    <= snz_d;
      sbad_q   <= sbad_d;
      pcount_q <= pcount_d;
      ended_q  <= ended_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/manifest_line_parser.sv @@
// Streaming parser for one manifest line (digest, size, path), one result per byte.
// Takes one byte per clock while the result side keeps taking beats and returns one
// result beat per byte, through the input register and then the result register. A
// new byte is accepted every cycle while the result side keeps taking beats; the
// path between the two registers is the classifier and the 64-bit times-ten-plus-digit
// add of the size field. A zero byte gives the end beat with the verdict and returns
// the parser to the start of a new line.
`default_nettype none

module manifest_line_parser #(
  parameter int unsigned PATH_BYTES = mlp_pkg::PATH_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  byte_kind_o,
  output logic [3:0]  nibble_o,
  output logic [63:0] size_value_o,
  output logic [6:0]  digest_length_o,
  output logic [8:0]  path_length_o,
  output logic        status_o,
  output logic        done_res_o
);

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             out_valid_q;
  mlp_pkg::result_t res_d, res_q;
  logic             advance;

  // a byte moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  mlp_core #(
    .PATH_BYTES (PATH_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .text_byte_i (byte_q),
    .result_o    (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= text_byte_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // result beat
  assign out_valid_o     = out_valid_q;
  assign byte_kind_o     = res_q.kind;
  assign nibble_o        = res_q.nibble;
  assign size_value_o    = res_q.size;
  assign digest_length_o = res_q.digest_len;
  assign path_length_o   = res_q.plen;
  assign status_o        = res_q.status;
  assign done_res_o      = res_q.done;

endmodule

`default_nettype wire
